// ===== rtl/nta_pkg.sv =====
// ----------------------------------------------------------------------------
// Neighbor table aging package
// Shared request and status codes, slot layout and controller interface types.
// ----------------------------------------------------------------------------
package nta_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_DELETE  = 3'd3;
    localparam logic [2:0] OP_LOOKUP  = 3'd4;
    localparam logic [2:0] OP_COUNT   = 3'd5;
    localparam logic [2:0] OP_FIRST   = 3'd6;
    localparam logic [2:0] OP_LIST    = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_PRESENT   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [15:0] HOLD_RESET = 16'd105;

    localparam int MAX_RESULTS  = 16;
    localparam int RUN_W        = 5;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 48;

    typedef struct packed {
        logic [15:0] remaining;
        logic [31:0] address;
        logic [7:0]  iface;
    } slot_t;

    typedef struct packed {
        logic start;
        logic rd_en;
        logic eval_en;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic data_valid;
        logic more;
        logic stall;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/nta_datapath.sv =====
// ----------------------------------------------------------------------------
// Neighbor table aging datapath
// Slot memory, scan and compaction pointers, accumulators and result register.
// ----------------------------------------------------------------------------
module nta_datapath
    import nta_pkg::*;
#(
    parameter int TABLE_CAPACITY = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,
    input  logic [IN_TDATA_W-1:0]  in_tdata,
    input  logic [2:0]             in_tuser,
    input  ctl_cmd_t               cmd,
    output dp_sts_t                sts,
    output logic                   out_tvalid,
    input  logic                   out_tready,
    output logic [OUT_TDATA_W-1:0] out_tdata,
    output logic                   out_tlast
);

    localparam int IDX_W = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
    localparam int CNT_W = $clog2(TABLE_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(TABLE_CAPACITY);

    slot_t slot_mem [TABLE_CAPACITY];
    slot_t rd_data_reg;

    logic [15:0]      hold_reg, hold_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             dv_reg, dv_next;
    logic             found_reg, found_next;
    logic             pend_reg, pend_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             out_valid_reg, out_valid_next;

    logic [2:0]  op_reg;
    logic [7:0]  ifc_reg;
    logic [31:0] addr_reg;
    logic [31:0] hit_addr_reg;

    logic [1:0]  out_status_reg;
    logic [7:0]  out_ifc_reg;
    logic [31:0] out_addr_reg;
    logic [4:0]  out_cnt_reg;
    logic        out_last_reg;

    logic             eval;
    logic             match_key;
    logic             match_ifc;
    logic             expire;
    logic             removes;
    logic             writes_back;
    logic             list_hit;
    logic             emit_mid;
    logic             out_free;
    logic             add_write;
    logic             out_load;
    slot_t            scan_wdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_t            mem_wdata;
    logic [31:0]      cnt_wide;
    logic [1:0]       fin_status;
    logic [7:0]       fin_ifc;
    logic [31:0]      fin_addr;
    logic [4:0]       fin_cnt;

    assign eval      = cmd.eval_en;
    assign match_ifc = (rd_data_reg.iface == ifc_reg);
    assign match_key = match_ifc && (rd_data_reg.address == addr_reg);
    assign expire    = (rd_data_reg.remaining <= 16'd1);
    assign out_free  = !out_valid_reg || out_tready;
    assign cnt_wide  = 32'(cnt_reg);

    always_comb
    begin
        removes     = ((op_reg == OP_TICK) && expire) || ((op_reg == OP_DELETE) && match_key);
        writes_back = (op_reg inside {OP_TICK, OP_REFRESH, OP_DELETE}) && !removes;
        list_hit    = (op_reg == OP_LIST) && match_ifc && (run_reg < RUN_W'(MAX_RESULTS));
        emit_mid    = list_hit && pend_reg;
        scan_wdata  = rd_data_reg;
        if (op_reg == OP_TICK)
        begin
            scan_wdata.remaining = rd_data_reg.remaining - 16'd1;
        end
        else if ((op_reg == OP_REFRESH) && match_key)
        begin
            scan_wdata.remaining = hold_reg;
        end
    end

    assign sts.data_valid = dv_reg;
    assign sts.more       = (rd_idx_reg < used_reg);
    assign sts.stall      = dv_reg && emit_mid && !out_free;
    assign sts.out_free   = out_free;

    assign add_write = cmd.finish && (op_reg == OP_ADD) && !found_reg && (used_reg < CAP_CNT);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_idx_reg[IDX_W-1:0];
        mem_wdata = scan_wdata;
        if (eval && writes_back)
        begin
            mem_we = 1'b1;
        end
        else if (add_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = used_reg[IDX_W-1:0];
            mem_wdata = '{remaining: hold_reg, address: addr_reg, iface: ifc_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= slot_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        fin_status = ST_OK;
        fin_ifc    = 8'd0;
        fin_addr   = 32'd0;
        fin_cnt    = 5'd0;
        case (op_reg)
            OP_TICK, OP_COUNT:
            begin
                fin_cnt = cnt_wide[4:0];
            end
            OP_ADD:
            begin
                if (found_reg)
                begin
                    fin_status = ST_PRESENT;
                end
                else if (used_reg >= CAP_CNT)
                begin
                    fin_status = ST_FULL;
                end
            end
            OP_REFRESH, OP_DELETE, OP_LOOKUP:
            begin
                fin_status = found_reg ? ST_OK : ST_NOT_FOUND;
            end
            OP_FIRST:
            begin
                if (found_reg)
                begin
                    fin_ifc  = ifc_reg;
                    fin_addr = hit_addr_reg;
                end
                else
                begin
                    fin_status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                if (pend_reg)
                begin
                    fin_ifc  = ifc_reg;
                    fin_addr = hit_addr_reg;
                end
                else
                begin
                    fin_status = ST_NOT_FOUND;
                end
            end
        endcase
    end

    assign out_load = (eval && emit_mid) || cmd.finish;

    always_comb
    begin
        hold_next      = cfg_wr_en ? cfg_wr_data : hold_reg;
        used_next      = used_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        pend_next      = pend_reg;
        run_next       = run_reg;
        dv_next        = dv_reg;
        out_valid_next = out_valid_reg;

        if (out_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        if (cmd.start)
        begin
            rd_idx_next = '0;
            wr_idx_next = '0;
            cnt_next    = '0;
            found_next  = 1'b0;
            pend_next   = 1'b0;
            run_next    = '0;
            dv_next     = 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
                dv_next     = 1'b1;
            end
            else if (eval)
            begin
                dv_next = 1'b0;
            end
            if (eval)
            begin
                if (writes_back)
                begin
                    wr_idx_next = wr_idx_reg + 1'b1;
                end
                if (((op_reg == OP_TICK) && removes) || ((op_reg == OP_COUNT) && match_ifc))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if ((op_reg inside {OP_ADD, OP_REFRESH, OP_DELETE, OP_LOOKUP}) && match_key)
                begin
                    found_next = 1'b1;
                end
                if ((op_reg == OP_FIRST) && match_ifc)
                begin
                    found_next = 1'b1;
                end
                if (list_hit)
                begin
                    pend_next = 1'b1;
                    run_next  = run_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                if (add_write)
                begin
                    used_next = used_reg + 1'b1;
                end
                else if (op_reg inside {OP_TICK, OP_REFRESH, OP_DELETE})
                begin
                    used_next = wr_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg      <= HOLD_RESET;
            used_reg      <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            run_reg       <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hold_reg      <= hold_next;
            used_reg      <= used_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            pend_reg      <= pend_next;
            run_reg       <= run_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg   <= in_tuser;
            ifc_reg  <= in_tdata[7:0];
            addr_reg <= in_tdata[39:8];
        end
        if (eval && (((op_reg == OP_FIRST) && match_ifc && !found_reg) || list_hit))
        begin
            hit_addr_reg <= rd_data_reg.address;
        end
        if (eval && emit_mid)
        begin
            out_status_reg <= ST_OK;
            out_ifc_reg    <= ifc_reg;
            out_addr_reg   <= hit_addr_reg;
            out_cnt_reg    <= 5'd0;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_status_reg <= fin_status;
            out_ifc_reg    <= fin_ifc;
            out_addr_reg   <= fin_addr;
            out_cnt_reg    <= fin_cnt;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = {1'b0, out_cnt_reg, out_addr_reg, out_ifc_reg, out_status_reg};
    assign out_tlast  = out_last_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CAP_CNT)
        else $error("Slot count exceeds the table capacity.");

    a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= rd_idx_reg)
        else $error("Compaction pointer ran ahead of the scan pointer.");

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (rd_idx_reg < used_reg))
        else $error("Scan read beyond the occupied slots.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_tready))
        else $error("Result register overwritten before it was taken.");

endmodule

// ===== rtl/nta_ctrl.sv =====
// ----------------------------------------------------------------------------
// Neighbor table aging controller
// Sequences request capture, the slot scan and the final result.
// ----------------------------------------------------------------------------
module nta_ctrl
    import nta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_tvalid,
    output logic     in_tready,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en   = sts.more && !sts.stall;
                cmd.eval_en = sts.data_valid && !sts.stall;
                if (!sts.more && !sts.stall)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/neighbor_table_aging.sv =====
// ----------------------------------------------------------------------------
// Neighbor table with aging timers
// Insertion-ordered neighbor table with per-entry liveness countdowns.
// The final result of an item is registered once the scan over the used slots is done
// and the result register is free. A new item is accepted only in idle, after the
// previous item's final result is loaded. The scan reads one slot per cycle from the
// slot memory; list results may add stalls.
// Reset: the table is empty and hold_ticks is 105; no clearing pass is needed.
// ----------------------------------------------------------------------------
module neighbor_table_aging
    import nta_pkg::*;
#(
    parameter int TABLE_CAPACITY = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,     // hold_ticks
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // neighbor_interface, neighbor_address
    input  logic [2:0]             s_axis_tuser,    // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,    // status, entry_interface,
                                                    // entry_address, match_count
    output logic                   m_axis_tlast     // last_of_run
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    nta_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    nta_datapath #(
        .TABLE_CAPACITY (TABLE_CAPACITY)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_tdata    (s_axis_tdata),
        .in_tuser    (s_axis_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .out_tvalid  (m_axis_tvalid),
        .out_tready  (m_axis_tready),
        .out_tdata   (m_axis_tdata),
        .out_tlast   (m_axis_tlast)
    );

endmodule
